### hw/rtl/vrc_pkg.sv
// Shared types and constants for the voxel ray collision check block.
// No dependencies; vrc_intf and the core module import this package.
`default_nettype none

package vrc_pkg;

  localparam int unsigned CoordW  = 32;   // signed Q16.16 world coordinate
  localparam int unsigned SizeW   = 31;   // voxel edge length
  localparam int unsigned TolW    = 16;   // tie tolerance
  localparam int unsigned LimitW  = 12;   // step limit / step counter
  localparam int unsigned CfgW    = 31;   // widest configuration register
  localparam int unsigned VoxW    = 34;   // signed voxel index, room for stepping
  localparam int unsigned SmW     = 30;   // scaled direction magnitude
  localparam int unsigned TW      = 64;   // crossing distances

  localparam logic [TW-1:0] TNever = 64'h8000_0000_0000_0000;
  localparam logic [TW-1:0] TCap   = 64'h4000_0000_0000_0000;

  // operation codes
  localparam logic [1:0] OpSet   = 2'd0;
  localparam logic [1:0] OpRead  = 2'd1;
  localparam logic [1:0] OpCheck = 2'd2;
  localparam logic [1:0] OpNone  = 2'd3;

  // status codes
  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatOutside  = 2'd1;
  localparam logic [1:0] StatStepLim  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] RegVoxelSize = 2'd0;
  localparam logic [1:0] RegTieTol    = 2'd1;
  localparam logic [1:0] RegStepLimit = 2'd2;

  localparam logic [SizeW-1:0]  VoxelSizeRst = 31'd65536;
  localparam logic [TolW-1:0]   TieTolRst    = 16'd1;
  localparam logic [LimitW-1:0] StepLimitRst = 12'd1000;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VDIV,
    ST_VWAIT,
    ST_GRID,
    ST_RDWAIT,
    ST_PREP,
    ST_SQMUL,
    ST_SQACC,
    ST_SQRT,
    ST_SQWAIT,
    ST_SLMUL,
    ST_AXIS,
    ST_DTMUL,
    ST_TMDIV,
    ST_TMWAIT,
    ST_TDDIV,
    ST_TDWAIT,
    ST_WTEST,
    ST_WREAD,
    ST_WCHK,
    ST_DONE
  } vrc_state_e;

endpackage

`default_nettype wire

### hw/rtl/vrc_intf.sv
// Request and response channel interfaces of the voxel ray collision check.
// Depends on vrc_pkg for field widths.
`default_nettype none

interface vrc_req_if;
  import vrc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic signed [CoordW-1:0] ax;
  logic signed [CoordW-1:0] ay;
  logic signed [CoordW-1:0] az;
  logic signed [CoordW-1:0] bx;
  logic signed [CoordW-1:0] by;
  logic signed [CoordW-1:0] bz;
  logic                     new_occupied;

  modport source (output valid, operation, ax, ay, az, bx, by, bz, new_occupied,
                  input ready);
  modport sink   (input valid, operation, ax, ay, az, bx, by, bz, new_occupied,
                  output ready);
endinterface

interface vrc_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       voxel_occupied;
  logic       collision;

  modport source (output valid, status, voxel_occupied, collision, input ready);
  modport sink   (input valid, status, voxel_occupied, collision, output ready);
endinterface

`default_nettype wire

### hw/rtl/voxel_ray_collision_check_core.sv
// Voxel occupancy grid with segment collision check: sequencer and datapath.
// Depends on vrc_pkg, vrc_intf, vrc_div, vrc_isqrt and vrc_grid.
//
// The block holds a GRID_DIM^3 grid of one-bit voxels. A request transaction
// either sets or reads the voxel holding point A, or walks the segment A->B
// voxel by voxel and reports whether any voxel after the start is occupied.
// One transaction is processed at a time. The finished response is parked in
// an output register, so the request channel reopens while that response
// waits; a later result waits in its last state until the register is free.
// Run time is set by the single shared 64/32 divider, which produces one
// quotient bit per cycle: set and read take three divisions. A check takes
// six index divisions, up to six more for the crossing distances, a square
// root and a few multiplies of setup, then passes the decide, grid read and
// test states for each voxel step, or only the first two for a step that
// leaves the grid. After reset the block sweeps the memory to empty, one
// voxel per cycle, before it accepts a request; configuration writes are
// taken during the sweep as ever.
`default_nettype none

module voxel_ray_collision_check_core #(
  parameter int unsigned GRID_DIM = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_idx_i,
  input  wire logic [vrc_pkg::CfgW-1:0] cfg_data_i,
  vrc_req_if.sink                    req_i,
  vrc_rsp_if.source                  rsp_o
);

  import vrc_pkg::*;

  localparam int unsigned Depth = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned IdxW  = $clog2(GRID_DIM);

  vrc_state_e state_q, state_d;

  // configuration
  logic [SizeW-1:0]  size_q;
  logic [TolW-1:0]   tol_q;
  logic [LimitW-1:0] limit_q;
  logic [31:0]       esize;

  // latched request
  logic [1:0]         op_q;
  logic [CoordW-1:0]  crd_q [6];
  logic               newocc_q;

  // walk state
  logic [2:0]        vidx_q;
  logic [1:0]        ax_q;
  logic [VoxW-1:0]   cur_q [3];
  logic [VoxW-1:0]   end_q [3];
  logic [31:0]       rr_q  [3];
  logic [SmW-1:0]    sm_q  [3];
  logic              up_q  [3];
  logic              nz_q  [3];
  logic [63:0]       sum_q, prod_q, sl_q;
  logic [31:0]       len_q;
  logic [TW-1:0]     tmax_q [3];
  logic [TW-1:0]     tdel_q [3];
  logic [LimitW-1:0] cnt_q;
  logic [AddrW-1:0]  clr_q;

  // response being built
  logic [1:0] status_q;
  logic       occ_q, coll_q;

  // response output register
  logic       rsp_vld_q;
  logic [1:0] rsp_status_q;
  logic       rsp_occ_q, rsp_coll_q;
  logic       rsp_free;

  // shared units
  logic        div_start, div_done;
  logic [63:0] div_dvd, div_quo;
  logic [31:0] div_dvs, div_rem;
  logic        sq_start, sq_done;
  logic [31:0] sq_root;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // grid port
  logic             mem_we, mem_wd, mem_re, mem_rd;
  logic [AddrW-1:0] mem_wa, mem_ra;

  logic req_fire;
  assign req_fire = req_i.valid && req_i.ready;

  // output register can take a new response this cycle
  assign rsp_free = !rsp_vld_q || rsp_o.ready;

  function automatic logic in_grid(input logic [VoxW-1:0] x, input logic [VoxW-1:0] y,
                                   input logic [VoxW-1:0] z);
    return !x[VoxW-1] && (x < VoxW'(GRID_DIM)) &&
           !y[VoxW-1] && (y < VoxW'(GRID_DIM)) &&
           !z[VoxW-1] && (z < VoxW'(GRID_DIM));
  endfunction

  function automatic logic [AddrW-1:0] grid_addr(input logic [VoxW-1:0] x,
                                                 input logic [VoxW-1:0] y,
                                                 input logic [VoxW-1:0] z);
    logic [AddrW-1:0] xa, ya, za;
    xa = AddrW'(x[IdxW-1:0]);
    ya = AddrW'(y[IdxW-1:0]);
    za = AddrW'(z[IdxW-1:0]);
    return AddrW'((xa * AddrW'(GRID_DIM) + ya) * AddrW'(GRID_DIM) + za);
  endfunction

  assign esize = (size_q == '0) ? 32'd1 : {1'b0, size_q};

  //--------------------------------------------------------------------------
  // Index division: pick the coordinate, turn the unsigned quotient into a
  // floor index and the remainder into the offset of the point in its voxel.
  //--------------------------------------------------------------------------
  logic [CoordW-1:0] crd_sel;
  logic [31:0]       crd_mag;
  logic              crd_neg, rem_nz;
  logic [VoxW-1:0]   qv, fidx;
  logic [31:0]       frem;
  logic [1:0]        vaxis;

  always_comb begin
    crd_sel = crd_q[vidx_q];
    crd_neg = crd_sel[CoordW-1];
    crd_mag = crd_neg ? (~crd_sel + 32'd1) : crd_sel;
    rem_nz  = div_rem != '0;
    qv      = VoxW'(div_quo[31:0]);
    fidx    = crd_neg ? (VoxW'(0) - qv - VoxW'(rem_nz)) : qv;
    frem    = (crd_neg && rem_nz) ? (esize - div_rem) : div_rem;
    vaxis   = (vidx_q < 3'd3) ? vidx_q[1:0] : 2'(vidx_q - 3'd3);
  end

  //--------------------------------------------------------------------------
  // Direction setup: d = B - A, scale down so every magnitude fits 30 bits.
  //--------------------------------------------------------------------------
  logic [32:0] dd   [3];
  logic [31:0] dmag [3];
  logic [31:0] dmax;
  logic [1:0]  kshf;
  logic [31:0] dsh  [3];
  logic [SmW-1:0] smn [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd[i]   = {crd_q[i+3][CoordW-1], crd_q[i+3]} - {crd_q[i][CoordW-1], crd_q[i]};
      dmag[i] = dd[i][32] ? 32'(~dd[i] + 33'd1) : dd[i][31:0];
    end
    dmax = dmag[0];
    if (dmag[1] > dmax) dmax = dmag[1];
    if (dmag[2] > dmax) dmax = dmag[2];
    kshf = dmax[31] ? 2'd2 : (dmax[30] ? 2'd1 : 2'd0);
    for (int i = 0; i < 3; i++) begin
      dsh[i] = dmag[i] >> kshf;
      smn[i] = ((dmag[i] != '0) && (dsh[i] == '0)) ? SmW'(1) : dsh[i][SmW-1:0];
    end
  end

  //--------------------------------------------------------------------------
  // Walk decision: stop tests, axis choice, saturating crossing update.
  //--------------------------------------------------------------------------
  logic          at_end, tie, lim;
  logic [TW-1:0] df01, df02, tsum, tnew;
  logic [1:0]    wsel;
  logic [VoxW-1:0] nstep;

  always_comb begin
    at_end = (cur_q[0] == end_q[0]) && (cur_q[1] == end_q[1]) && (cur_q[2] == end_q[2]);
    df01 = (tmax_q[0] > tmax_q[1]) ? tmax_q[0] - tmax_q[1] : tmax_q[1] - tmax_q[0];
    df02 = (tmax_q[0] > tmax_q[2]) ? tmax_q[0] - tmax_q[2] : tmax_q[2] - tmax_q[0];
    tie  = (df01 < TW'(tol_q)) && (df02 < TW'(tol_q));
    lim  = cnt_q >= limit_q;
    if (tmax_q[0] < tmax_q[1] && tmax_q[0] < tmax_q[2]) begin
      wsel = 2'd0;
    end else if (tmax_q[1] < tmax_q[2]) begin
      wsel = 2'd1;
    end else begin
      wsel = 2'd2;
    end
    tsum = tmax_q[wsel] + tdel_q[wsel];
    if (tmax_q[wsel][TW-1]) begin
      tnew = tmax_q[wsel];
    end else if (tsum[TW-1] || tsum[TW-2]) begin
      tnew = TCap;
    end else begin
      tnew = tsum;
    end
    nstep = up_q[wsel] ? VoxW'(1) : (nz_q[wsel] ? '1 : '0);
  end

  logic a_in, w_in;
  assign a_in = in_grid(cur_q[0], cur_q[1], cur_q[2]);
  assign w_in = a_in;

  //--------------------------------------------------------------------------
  // Next state
  //--------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_q == AddrW'(Depth - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (req_fire) begin
          state_d = (req_i.operation == OpNone) ? ST_DONE : ST_VDIV;
        end
      end
      ST_VDIV:   state_d = ST_VWAIT;
      ST_VWAIT: begin
        if (div_done) begin
          if (vidx_q == 3'd2 && op_q != OpCheck) begin
            state_d = ST_GRID;
          end else if (vidx_q == 3'd5) begin
            state_d = ST_PREP;
          end else begin
            state_d = ST_VDIV;
          end
        end
      end
      ST_GRID:   state_d = (op_q == OpRead && a_in) ? ST_RDWAIT : ST_DONE;
      ST_RDWAIT: state_d = ST_DONE;
      ST_PREP:   state_d = ST_SQMUL;
      ST_SQMUL:  state_d = ST_SQACC;
      ST_SQACC:  state_d = (ax_q == 2'd2) ? ST_SQRT : ST_SQMUL;
      ST_SQRT:   state_d = ST_SQWAIT;
      ST_SQWAIT: if (sq_done) state_d = ST_SLMUL;
      ST_SLMUL:  state_d = ST_AXIS;
      ST_AXIS: begin
        if (nz_q[ax_q]) begin
          state_d = ST_DTMUL;
        end else if (ax_q == 2'd2) begin
          state_d = ST_WTEST;
        end
      end
      ST_DTMUL:  state_d = ST_TMDIV;
      ST_TMDIV:  state_d = ST_TMWAIT;
      ST_TMWAIT: if (div_done) state_d = ST_TDDIV;
      ST_TDDIV:  state_d = ST_TDWAIT;
      ST_TDWAIT: begin
        if (div_done) state_d = (ax_q == 2'd2) ? ST_WTEST : ST_AXIS;
      end
      ST_WTEST:  state_d = (at_end || tie || lim) ? ST_DONE : ST_WREAD;
      ST_WREAD:  state_d = w_in ? ST_WCHK : ST_WTEST;
      ST_WCHK:   state_d = mem_rd ? ST_DONE : ST_WTEST;
      ST_DONE:   if (rsp_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  //--------------------------------------------------------------------------
  // Outputs to the channels and shared units
  //--------------------------------------------------------------------------
  logic [31:0] dist_sel;
  assign dist_sel = up_q[ax_q] ? (esize - rr_q[ax_q]) : rr_q[ax_q];

  always_comb begin
    req_i.ready = 1'b0;
    div_start   = 1'b0;
    div_dvd     = 64'(crd_mag);
    div_dvs     = esize;
    sq_start    = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = grid_addr(cur_q[0], cur_q[1], cur_q[2]);
    mem_wd      = newocc_q;
    mem_re      = 1'b0;
    mem_ra      = grid_addr(cur_q[0], cur_q[1], cur_q[2]);
    mul_a       = 32'(sm_q[ax_q]);
    mul_b       = 32'(sm_q[ax_q]);
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = 1'b0;
      end
      ST_IDLE:  req_i.ready = 1'b1;
      ST_VDIV:  div_start = 1'b1;
      ST_GRID: begin
        mem_we = (op_q == OpSet) && a_in;
        mem_re = (op_q == OpRead) && a_in;
      end
      ST_SQRT:  sq_start = 1'b1;
      ST_SLMUL: begin
        mul_a = esize;
        mul_b = len_q;
      end
      ST_DTMUL: begin
        mul_a = dist_sel;
        mul_b = len_q;
      end
      ST_TMDIV: begin
        div_start = 1'b1;
        div_dvd   = prod_q;
        div_dvs   = 32'(sm_q[ax_q]);
      end
      ST_TDDIV: begin
        div_start = 1'b1;
        div_dvd   = sl_q;
        div_dvs   = 32'(sm_q[ax_q]);
      end
      ST_WREAD: mem_re = w_in;
      default: ;
    endcase
  end

  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

  assign rsp_o.valid          = rsp_vld_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.voxel_occupied = rsp_occ_q;
  assign rsp_o.collision      = rsp_coll_q;

  //--------------------------------------------------------------------------
  // Control registers
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      size_q    <= VoxelSizeRst;
      tol_q     <= TieTolRst;
      limit_q   <= StepLimitRst;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AddrW'(1);
      end
      // load the output register when a result is done, drop it once taken
      if (state_q == ST_DONE && rsp_free) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegVoxelSize: size_q  <= cfg_data_i[SizeW-1:0];
          RegTieTol:    tol_q   <= cfg_data_i[TolW-1:0];
          RegStepLimit: limit_q <= cfg_data_i[LimitW-1:0];
          default: ;
        endcase
      end
    end
  end

  //--------------------------------------------------------------------------
  // Datapath registers
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          op_q     <= req_i.operation;
          crd_q[0] <= req_i.ax;
          crd_q[1] <= req_i.ay;
          crd_q[2] <= req_i.az;
          crd_q[3] <= req_i.bx;
          crd_q[4] <= req_i.by;
          crd_q[5] <= req_i.bz;
          newocc_q <= req_i.new_occupied;
          vidx_q   <= '0;
          status_q <= StatOk;
          occ_q    <= 1'b0;
          coll_q   <= 1'b0;
        end
      end
      ST_VWAIT: begin
        if (div_done) begin
          if (vidx_q < 3'd3) begin
            cur_q[vaxis] <= fidx;
            rr_q[vaxis]  <= frem;
          end else begin
            end_q[vaxis] <= fidx;
          end
          vidx_q <= vidx_q + 3'd1;
        end
      end
      ST_GRID: begin
        // drop a set outside the grid and flag it
        if (op_q == OpSet && !a_in) status_q <= StatOutside;
      end
      ST_RDWAIT: occ_q <= mem_rd;
      ST_PREP: begin
        for (int i = 0; i < 3; i++) begin
          sm_q[i] <= smn[i];
          nz_q[i] <= dd[i] != '0;
          up_q[i] <= !dd[i][32] && (dd[i] != '0);
        end
        sum_q <= '0;
        ax_q  <= '0;
      end
      ST_SQMUL:  prod_q <= mul_p;
      ST_SQACC: begin
        sum_q <= sum_q + prod_q;
        ax_q  <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
      end
      ST_SQWAIT: if (sq_done) len_q <= sq_root;
      ST_SLMUL: begin
        sl_q <= mul_p;
        ax_q <= '0;
      end
      ST_AXIS: begin
        if (!nz_q[ax_q]) begin
          // axis never crosses a plane
          tmax_q[ax_q] <= TNever;
          tdel_q[ax_q] <= '0;
          if (ax_q != 2'd2) ax_q <= ax_q + 2'd1;
        end
        cnt_q <= '0;
      end
      ST_DTMUL:  prod_q <= mul_p;
      ST_TMWAIT: if (div_done) tmax_q[ax_q] <= div_quo;
      ST_TDWAIT: begin
        if (div_done) begin
          tdel_q[ax_q] <= div_quo;
          if (ax_q != 2'd2) ax_q <= ax_q + 2'd1;
        end
      end
      ST_WTEST: begin
        if (!at_end && !tie && lim) begin
          status_q <= StatStepLim;
        end else if (!at_end && !tie) begin
          tmax_q[wsel] <= tnew;
          cur_q[wsel]  <= cur_q[wsel] + nstep;
          cnt_q        <= cnt_q + LimitW'(1);
        end
      end
      ST_WCHK:   if (mem_rd) coll_q <= 1'b1;
      ST_DONE: begin
        if (rsp_free) begin
          rsp_status_q <= status_q;
          rsp_occ_q    <= occ_q;
          rsp_coll_q   <= coll_q;
        end
      end
      default: ;
    endcase
  end

  //--------------------------------------------------------------------------
  // Shared units
  //--------------------------------------------------------------------------
  vrc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  vrc_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sum_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  vrc_grid #(
    .ADDR_W (AddrW)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (mem_wd),
    .re_i    (mem_re),
    .raddr_i (mem_ra),
    .rdata_o (mem_rd)
  );

endmodule

`default_nettype wire

### hw/rtl/vrc_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
// 64-bit dividend by 32-bit divisor; no package dependencies.
`default_nettype none

module vrc_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [63:0]      quo_o,
  output logic [31:0]      rem_o
);

  logic [63:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q;
  logic [5:0]  cnt_q;
  logic        run_q, done_q;
  logic [32:0] rem_sh;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[63]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = ge ? 32'(rem_sh - {1'b0, dvs_q}) : rem_sh[31:0];
    quo_d  = {quo_q[62:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

### hw/rtl/vrc_isqrt.sv
// Iterative floor integer square root, one result bit per cycle.
// 64-bit radicand, 32-bit root; no package dependencies.
`default_nettype none

module vrc_isqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] value_i,
  output logic             done_o,
  output logic [31:0]      root_o
);

  logic [63:0] n_q, res_q, bit_q;
  logic [63:0] trial;
  logic        run_q, done_q;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
      end else if (run_q && bit_q[0]) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= value_i;
      res_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (run_q) begin
      if (n_q >= trial) begin
        n_q   <= n_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];

endmodule

`default_nettype wire

### hw/rtl/vrc_grid.sv
// One-bit occupancy memory: one write port, one read port, registered read.
// No package dependencies.
`default_nettype none

module vrc_grid #(
  parameter int unsigned ADDR_W = 18
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic              wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic                   rdata_o
);

  logic mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire
